// File: hw/rtl/assert_macros.svh
// Assertion macros used by the route table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/dvrt_pkg.sv
// Package: types and constants for the distance-vector route table
package dvrt_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [4:0] METRIC_INF = 5'd16;

    localparam logic [1:0] KIND_ADV = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;

    localparam logic [1:0] REG_ROUTE_TO = 2'd0;
    localparam logic [1:0] REG_GARB_TO = 2'd1;
    localparam logic [1:0] REG_HOP = 2'd2;

    localparam logic [2:0] ST_REFRESHED = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_BAD_METRIC = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_TICK_DONE = 3'd4;
    localparam logic [2:0] ST_READ_VALID = 3'd5;
    localparam logic [2:0] ST_READ_EMPTY = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] adv_subnet;
        logic [31:0] adv_mask;
        logic [7:0]  adv_metric;
        logic [31:0] from_addr;
        logic [5:0]  read_slot;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  route_count;
        logic        any_changed;
        logic [15:0] min_time_left;
        logic [31:0] read_subnet;
        logic [31:0] read_mask;
        logic [31:0] read_next_hop;
        logic [4:0]  read_metric;
        logic [15:0] read_time_left;
        logic        read_changed;
    } rsp_t;
endpackage

// File: hw/rtl/dvrt_if.sv
// Valid/ready channel interface carrying one payload struct
interface dvrt_req_if import dvrt_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dvrt_rsp_if import dvrt_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/distance_vector_route_table_unit.sv
// Distance-vector route table: one slot walked per cycle by a small sequencer.
// Every request walks all TABLE_DEPTH slots once to scan and update (through the
// registered read), passes through the update state, then walks them again to sum
// count, change flag and least timer, and loads the result in the output state; a
// read takes the same path. A new request is accepted only after the result has
// been taken. The slot memory has one read and one write port. in.ready is high
// only in idle with no result waiting.
module distance_vector_route_table_unit import dvrt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    dvrt_req_if.sink    in,
    dvrt_rsp_if.source  out
);
`include "assert_macros.svh"

    // configuration
    logic [15:0] route_to_reg, garb_to_reg;
    logic [3:0]  hop_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_to_reg <= 16'd180;
            garb_to_reg  <= 16'd120;
            hop_reg      <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTE_TO: route_to_reg <= cfg_data;
                REG_GARB_TO:  garb_to_reg <= cfg_data;
                REG_HOP:      hop_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // slot storage: valid and change bits in flops, payload in memory
    logic [TABLE_DEPTH-1:0] valid_reg, chg_reg;
    logic [31:0] mem_subnet [TABLE_DEPTH];
    logic [31:0] mem_mask [TABLE_DEPTH];
    logic [31:0] mem_hop [TABLE_DEPTH];
    logic [4:0]  mem_metric [TABLE_DEPTH];
    logic [15:0] mem_timer [TABLE_DEPTH];

    state_t state_reg, state_next;
    req_t req_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;   // read address (walks one ahead)
    logic [SLOT_W-1:0] cur_reg;             // slot whose data is in rd_*
    logic rd_live_reg;
    logic [31:0] rd_subnet, rd_mask, rd_hop;
    logic [4:0]  rd_metric;
    logic [15:0] rd_timer;
    logic hit_found_reg, free_found_reg;
    logic [SLOT_W-1:0] hit_reg, free_reg;
    logic [31:0] hit_hop_reg;               // next hop of the matching slot
    logic [4:0]  hit_metric_reg;            // metric of the matching slot
    logic [6:0]  cnt_reg;
    logic        anychg_reg;
    logic [15:0] least_reg;
    rsp_t rsp_reg;
    logic out_valid_reg;

    // registered memory reads
    always_ff @(posedge clk)
    begin
        rd_subnet <= mem_subnet[idx_reg[SLOT_W-1:0]];
        rd_mask   <= mem_mask[idx_reg[SLOT_W-1:0]];
        rd_hop    <= mem_hop[idx_reg[SLOT_W-1:0]];
        rd_metric <= mem_metric[idx_reg[SLOT_W-1:0]];
        rd_timer  <= mem_timer[idx_reg[SLOT_W-1:0]];
    end

    logic metric_bad;
    logic [4:0] new_metric;
    logic [5:0] msum;
    assign metric_bad = (req_reg.adv_metric == 8'd0) || (req_reg.adv_metric > 8'd16);
    assign msum = {1'b0, req_reg.adv_metric[4:0]} + {2'b0, hop_reg};
    assign new_metric = (msum > 6'd16) ? METRIC_INF : msum[4:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (in.valid && in.ready) state_next = S_SCAN;
            S_SCAN:
                if (rd_live_reg && cur_reg == SLOT_W'(TABLE_DEPTH - 1))
                    state_next = S_UPDATE;
            S_UPDATE: state_next = S_SUM;
            S_SUM:    if (idx_reg == CNT_W'(TABLE_DEPTH)) state_next = S_OUT;
            S_OUT:    if (!out_valid_reg) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        case (state_reg)
            S_IDLE:   idx_next = '0;
            S_SCAN:   if (idx_reg != CNT_W'(TABLE_DEPTH)) idx_next = idx_reg + 1'b1;
            S_UPDATE: idx_next = '0;
            S_SUM:    if (idx_reg != CNT_W'(TABLE_DEPTH)) idx_next = idx_reg + 1'b1;
            default:  idx_next = idx_reg;
        endcase
    end

    assign in.ready = (state_reg == S_IDLE) && !out_valid_reg;

    // tick update for the current slot, and advertisement update of the matching or free slot
    logic [15:0] dec_timer;
    assign dec_timer = (rd_timer != 16'd0) ? rd_timer - 16'd1 : 16'd0;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && rd_live_reg && req_reg.kind == KIND_TICK
            && valid_reg[cur_reg])
        begin
            if (dec_timer == 16'd0 && rd_metric != METRIC_INF)
            begin
                mem_metric[cur_reg] <= METRIC_INF;
                mem_timer[cur_reg]  <= garb_to_reg;
            end
            else
                mem_timer[cur_reg] <= dec_timer;
        end
        else if (state_reg == S_UPDATE && req_reg.kind == KIND_ADV && !metric_bad)
        begin
            if (hit_found_reg)
            begin
                if (hit_hop_reg == req_reg.from_addr || new_metric < hit_metric_reg)
                begin
                    mem_hop[hit_reg]    <= req_reg.from_addr;
                    mem_metric[hit_reg] <= new_metric;
                    mem_timer[hit_reg]  <= (new_metric == METRIC_INF) ? garb_to_reg
                                                                       : route_to_reg;
                end
                else
                    mem_timer[hit_reg] <= (hit_metric_reg == METRIC_INF) ? garb_to_reg
                                                                         : route_to_reg;
            end
            else if (free_found_reg)
            begin
                mem_subnet[free_reg] <= req_reg.adv_subnet;
                mem_mask[free_reg]   <= req_reg.adv_mask;
                mem_hop[free_reg]    <= req_reg.from_addr;
                mem_metric[free_reg] <= new_metric;
                mem_timer[free_reg]  <= (new_metric == METRIC_INF) ? garb_to_reg
                                                                   : route_to_reg;
            end
        end
    end

    // control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            cur_reg <= '0;
            rd_live_reg <= 1'b0;
            valid_reg <= '0;
            chg_reg <= '0;
            hit_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg <= '0;
            free_reg <= '0;
            hit_hop_reg <= '0;
            hit_metric_reg <= '0;
            cnt_reg <= '0;
            anychg_reg <= 1'b0;
            least_reg <= '0;
            out_valid_reg <= 1'b0;
            req_reg <= '0;
            rsp_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cur_reg <= idx_reg[SLOT_W-1:0];
            rd_live_reg <= (state_reg == S_SCAN || state_reg == S_SUM)
                           && idx_reg != CNT_W'(TABLE_DEPTH);
            if (out_valid_reg && out.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in.valid && in.ready)
                    begin
                        req_reg <= in.data;
                        hit_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        rsp_reg <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (rd_live_reg)
                    begin
                        if (valid_reg[cur_reg])
                        begin
                            if (!hit_found_reg && rd_subnet == req_reg.adv_subnet
                                && rd_mask == req_reg.adv_mask)
                            begin
                                hit_found_reg <= 1'b1;
                                hit_reg <= cur_reg;
                                hit_hop_reg <= rd_hop;
                                hit_metric_reg <= rd_metric;
                            end
                            if (req_reg.kind == KIND_TICK && dec_timer == 16'd0
                                && rd_metric == METRIC_INF)
                            begin
                                valid_reg[cur_reg] <= 1'b0;
                                chg_reg[cur_reg] <= 1'b0;
                            end
                        end
                        else if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_reg <= cur_reg;
                        end
                        // read request: capture slot contents
                        if (req_reg.kind[1] && cur_reg == req_reg.read_slot[SLOT_W-1:0]
                            && valid_reg[cur_reg])
                        begin
                            rsp_reg.read_subnet <= rd_subnet;
                            rsp_reg.read_mask <= rd_mask;
                            rsp_reg.read_next_hop <= rd_hop;
                            rsp_reg.read_metric <= rd_metric;
                            rsp_reg.read_time_left <= rd_timer;
                            rsp_reg.read_changed <= chg_reg[cur_reg];
                        end
                    end
                end
                S_UPDATE:
                begin
                    cnt_reg <= '0;
                    anychg_reg <= 1'b0;
                    least_reg <= route_to_reg;
                    if (req_reg.kind == KIND_ADV)
                    begin
                        if (metric_bad)
                            rsp_reg.status <= ST_BAD_METRIC;
                        else if (hit_found_reg)
                        begin
                            rsp_reg.status <= ST_REFRESHED;
                            chg_reg[hit_reg] <= 1'b1;
                        end
                        else if (free_found_reg)
                        begin
                            rsp_reg.status <= ST_ADDED;
                            valid_reg[free_reg] <= 1'b1;
                            chg_reg[free_reg] <= 1'b1;
                        end
                        else
                            rsp_reg.status <= ST_FULL;
                    end
                    else if (req_reg.kind == KIND_TICK)
                        rsp_reg.status <= ST_TICK_DONE;
                    else if ({1'b0, req_reg.read_slot} < 7'(TABLE_DEPTH)
                             && valid_reg[req_reg.read_slot[SLOT_W-1:0]])
                        rsp_reg.status <= ST_READ_VALID;
                    else
                    begin
                        rsp_reg.status <= ST_READ_EMPTY;
                        rsp_reg.read_subnet <= '0;
                        rsp_reg.read_mask <= '0;
                        rsp_reg.read_next_hop <= '0;
                        rsp_reg.read_metric <= '0;
                        rsp_reg.read_time_left <= '0;
                        rsp_reg.read_changed <= 1'b0;
                    end
                end
                S_SUM:
                begin
                    if (rd_live_reg && valid_reg[cur_reg])
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                        if (chg_reg[cur_reg])
                            anychg_reg <= 1'b1;
                        if (rd_timer < least_reg)
                            least_reg <= rd_timer;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        rsp_reg.route_count <= cnt_reg;
                        rsp_reg.any_changed <= anychg_reg;
                        rsp_reg.min_time_left <= least_reg;
                        out_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out.valid = out_valid_reg;
    assign out.data = rsp_reg;

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in.ready)
    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in.valid && in.ready, state_reg == S_SCAN)
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, out_valid_reg,
        rsp_reg.route_count <= 7'(TABLE_DEPTH))
endmodule
